### sv/cbcc_pkg.sv
`default_nettype none

package cbcc_pkg;

   // width of the mask fields on the ports
   localparam int FIELD_W = 31;

   // widest residue mask handled by the bit counter, and its count width
   localparam int MASK_W = 64;
   localparam int POP_W  = 7;

   // verdict of one candidate check
   typedef struct packed {
      logic all_ok;
      logic first_ok;
      logic second_ok;
      logic cross_ok;
   } cbcc_verdict_type;

   // number of set bits in a residue mask, summed as a balanced adder tree
   function automatic logic [POP_W-1:0] popcount(input logic [MASK_W-1:0] value);
      logic [POP_W-1:0] level [MASK_W];
      for (int i = 0; i < MASK_W; i++) begin
         level[i] = POP_W'(value[i]);
      end
      for (int w = MASK_W / 2; w >= 1; w = w / 2) begin
         for (int i = 0; i < w; i++) begin
            level[i] = level[2 * i] + level[2 * i + 1];
         end
      end
      return level[0];
   endfunction

endpackage

`default_nettype wire

### sv/cbcc_setup.sv
`default_nettype none

module cbcc_setup #(
   parameter int PRIME = 31,
   parameter int BOOK  = 16,
   localparam int BUD_W = $clog2(PRIME + BOOK + 2) + 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [cbcc_pkg::FIELD_W-1:0]    csr_first_set,
   output logic      [PRIME-1:0]                first_mask,
   output logic signed [BUD_W-1:0]              first_budget [PRIME],
   output logic signed [BUD_W-1:0]              second_budget [PRIME],
   output logic                                 pending
);

   localparam int EXT_W = (PRIME > cbcc_pkg::FIELD_W) ? PRIME : cbcc_pkg::FIELD_W;

   logic [cbcc_pkg::FIELD_W-1:0] first_set_ff;
   logic [cbcc_pkg::FIELD_W-1:0] first_set_in;
   logic [EXT_W-1:0]             set_ext;
   logic [PRIME-1:0]             s11;
   logic [PRIME-1:0]             s22;
   logic [PRIME-1:0]             mask_ff;
   logic signed [BUD_W-1:0]      bud1_ff [PRIME];
   logic signed [BUD_W-1:0]      bud1_in [PRIME];
   logic signed [BUD_W-1:0]      bud2_ff [PRIME];
   logic signed [BUD_W-1:0]      bud2_in [PRIME];
   logic                         pending_ff;
   logic                         pending_in;

   // register write
   assign first_set_in = csr_write ? csr_first_set : first_set_ff;

   // residues at or above the prime drop out here
   assign set_ext = EXT_W'(first_set_ff);
   assign s11     = set_ext[PRIME-1:0];

   // complement set without residue zero
   always_comb begin
      s22    = ~s11;
      s22[0] = 1'b0;
   end

   // per-shift budgets left for the candidate self overlap
   always_comb begin
      logic [PRIME-1:0] r11;
      logic [PRIME-1:0] r22;
      int               lim1;
      int               lim2;
      for (int d = 0; d < PRIME; d++) begin
         for (int i = 0; i < PRIME; i++) begin
            r11[i] = s11[(i - d + PRIME) % PRIME];
            r22[i] = s22[(i - d + PRIME) % PRIME];
         end
         lim1 = s11[d] ? (BOOK - 2) : (BOOK + 1);
         lim2 = s11[d] ? (BOOK - 3) : (BOOK - 2);
         if (d == 0) begin
            // shift zero is never checked
            bud1_in[d] = '0;
            bud2_in[d] = '0;
         end else begin
            bud1_in[d] = BUD_W'(lim1 - int'(cbcc_pkg::popcount(
                            cbcc_pkg::MASK_W'(s11 & r11))));
            bud2_in[d] = BUD_W'(lim2 - int'(cbcc_pkg::popcount(
                            cbcc_pkg::MASK_W'(s22 & r22))));
         end
      end
   end

   // budgets are registered from the set register, so they settle in the cycle after it
   assign pending_in = csr_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_set_ff <= '0;
         pending_ff   <= 1'b1;
      end else begin
         first_set_ff <= first_set_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= s11;
      bud1_ff <= bud1_in;
      bud2_ff <= bud2_in;
   end

   assign first_mask    = mask_ff;
   assign first_budget  = bud1_ff;
   assign second_budget = bud2_ff;
   assign pending       = pending_ff;

endmodule

`default_nettype wire

### sv/cbcc_check.sv
`default_nettype none

module cbcc_check #(
   parameter int PRIME = 31,
   parameter int BOOK  = 16,
   localparam int BUD_W = $clog2(PRIME + BOOK + 2) + 1
) (
   input  wire logic [cbcc_pkg::FIELD_W-1:0]  candidate_set,
   input  wire logic [PRIME-1:0]              first_mask,
   input  wire logic signed [BUD_W-1:0]       first_budget [PRIME],
   input  wire logic signed [BUD_W-1:0]       second_budget [PRIME],
   output cbcc_pkg::cbcc_verdict_type         verdict
);

   localparam int EXT_W  = (PRIME > cbcc_pkg::FIELD_W) ? PRIME : cbcc_pkg::FIELD_W;
   localparam int HALF   = PRIME / 2;
   localparam int CNT_W  = $clog2(PRIME + 1);
   localparam int XW     = $clog2(2 * PRIME + 1);

   logic [EXT_W-1:0]      cand_ext;
   logic [PRIME-1:0]      s12;
   logic [PRIME-1:0]      s22;
   logic [PRIME-1:0]      neg12;
   logic [CNT_W-1:0]      self_cnt [HALF+1];
   logic                  ok1;
   logic                  ok2;
   logic                  okx;

   assign cand_ext = EXT_W'(candidate_set);
   assign s12      = cand_ext[PRIME-1:0];

   // complement of the configured set, residue zero removed
   always_comb begin
      s22    = ~first_mask;
      s22[0] = 1'b0;
   end

   // negated residues of the candidate
   always_comb begin
      neg12[0] = s12[0];
      for (int i = 1; i < PRIME; i++) begin
         neg12[i] = s12[PRIME - i];
      end
   end

   // candidate self overlap, symmetric in d and p-d
   always_comb begin
      logic [PRIME-1:0] r12;
      self_cnt[0] = '0;
      for (int d = 1; d <= HALF; d++) begin
         for (int i = 0; i < PRIME; i++) begin
            r12[i] = s12[(i - d + PRIME) % PRIME];
         end
         self_cnt[d] = CNT_W'(cbcc_pkg::popcount(cbcc_pkg::MASK_W'(s12 & r12)));
      end
   end

   // first and second block limits against the stored budgets
   always_comb begin
      logic signed [BUD_W-1:0] b_s;
      int                      e;
      ok1 = 1'b1;
      ok2 = 1'b1;
      for (int d = 1; d < PRIME; d++) begin
         e   = (d <= HALF) ? d : (PRIME - d);
         b_s = BUD_W'(self_cnt[e]);
         if (b_s > first_budget[d]) begin
            ok1 = 1'b0;
         end
         if (b_s > second_budget[d]) begin
            ok2 = 1'b0;
         end
      end
   end

   // cross overlap for every shift
   always_comb begin
      logic [PRIME-1:0] rneg;
      logic [PRIME-1:0] r22;
      logic [XW-1:0]    x;
      int               lim;
      okx = 1'b1;
      for (int d = 0; d < PRIME; d++) begin
         for (int i = 0; i < PRIME; i++) begin
            rneg[i] = neg12[(i - d + PRIME) % PRIME];
            r22[i]  = s22[(i - d + PRIME) % PRIME];
         end
         x = XW'(cbcc_pkg::popcount(cbcc_pkg::MASK_W'(first_mask & rneg)))
           + XW'(cbcc_pkg::popcount(cbcc_pkg::MASK_W'(s12 & r22)));
         lim = s12[d] ? (BOOK - 2) : (BOOK - 1);
         if (int'(x) > lim) begin
            okx = 1'b0;
         end
      end
   end

   assign verdict.first_ok  = ok1;
   assign verdict.second_ok = ok2;
   assign verdict.cross_ok  = okx;
   assign verdict.all_ok    = ok1 & ok2 & okx;

endmodule

`default_nettype wire

### sv/cyclic_book_coloring_check_core.sv
// Checks one candidate residue mask (D12) per cycle against the configured mask D11 and
// reports the V1V1, V2V2 and V1V2 verdicts plus their conjunction. Throughput is one
// candidate per clock while neither rsp_stall nor a limit refresh holds the stage; a result
// is presented from the result register after its input transfer, set by the input register
// and the result register with the overlap counters between them. The per-shift limits that
// depend only on D11 live in registers refreshed in the cycle after a csr transfer; during
// that cycle the check stage holds its item. The limits are loaded while reset is held, so a
// request is accepted straight after reset. Mask bits at or above PRIME are ignored.
`default_nettype none

module cyclic_book_coloring_check_core #(
   parameter int PRIME = 31,
   parameter int BOOK  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cbcc_pkg::FIELD_W-1:0]  req_candidate_set,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_passes,
   output logic                               rsp_first_block_ok,
   output logic                               rsp_second_block_ok,
   output logic                               rsp_cross_ok,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cbcc_pkg::FIELD_W-1:0]  csr_first_set
);

   localparam int BUD_W = $clog2(PRIME + BOOK + 2) + 1;

   logic                           csr_write;
   logic [PRIME-1:0]               first_mask;
   logic signed [BUD_W-1:0]        first_budget [PRIME];
   logic signed [BUD_W-1:0]        second_budget [PRIME];
   logic                           pending;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [cbcc_pkg::FIELD_W-1:0]   cand_ff;
   logic [cbcc_pkg::FIELD_W-1:0]   cand_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   cbcc_pkg::cbcc_verdict_type     verdict;
   cbcc_pkg::cbcc_verdict_type     verdict_ff;
   cbcc_pkg::cbcc_verdict_type     verdict_in;

   logic                           req_xfer;
   logic                           out_free;
   logic                           advance;

   // configuration channel is always open
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   cbcc_setup #(
      .PRIME (PRIME),
      .BOOK  (BOOK)
   ) u_setup (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_first_set (csr_first_set),
      .first_mask    (first_mask),
      .first_budget  (first_budget),
      .second_budget (second_budget),
      .pending       (pending)
   );

   cbcc_check #(
      .PRIME (PRIME),
      .BOOK  (BOOK)
   ) u_check (
      .candidate_set (cand_ff),
      .first_mask    (first_mask),
      .first_budget  (first_budget),
      .second_budget (second_budget),
      .verdict       (verdict)
   );

   // stage handshake
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & ~pending & out_free;
   assign req_stall = in_valid_ff & ~advance;
   assign req_xfer  = req_valid & ~req_stall;

   // input register
   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign cand_in = req_xfer ? req_candidate_set : cand_ff;

   // result register
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign verdict_in = advance ? verdict : verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_passes          = verdict_ff.all_ok;
   assign rsp_first_block_ok  = verdict_ff.first_ok;
   assign rsp_second_block_ok = verdict_ff.second_ok;
   assign rsp_cross_ok        = verdict_ff.cross_ok;

endmodule

`default_nettype wire

### sv/cbcc_checker.sv
`default_nettype none

module cbcc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_passes,
   input wire logic                          rsp_first_block_ok,
   input wire logic                          rsp_second_block_ok,
   input wire logic                          rsp_cross_ok,
   input wire logic                          csr_valid,
   input wire logic                          csr_ready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_passes)
         && $stable(rsp_first_block_ok) && $stable(rsp_second_block_ok)
         && $stable(rsp_cross_ok))
      else $error("stalled result changed");

   // overall verdict is the conjunction of the group verdicts
   a_conjunction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_passes == (rsp_first_block_ok && rsp_second_block_ok && rsp_cross_ok))
      else $error("overall verdict disagrees with group verdicts");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a transfer with no csr write and the result side then free yields a valid result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(csr_valid && csr_ready)) ##1 (!rsp_valid || !rsp_stall)
         |=> rsp_valid)
      else $error("result missing after input transfer");

endmodule

bind cyclic_book_coloring_check_core cbcc_checker u_checker (.*);

`default_nettype wire
